@@ src/lru_page_replacement_assert.svh @@
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property forms for the checker of the frame set.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define LPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, sampled on clk and quiet during reset.
`define LPR_ASSERT_LAT2(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

@@ src/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, types and reset values shared by the frame set modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_WIDTH  = 16;
    localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W      = FRAME_IDX_W;
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W       = 5;
    localparam int FAULT_W     = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef logic [PAGE_WIDTH-1:0]  page_t;
    typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
    typedef logic [RANK_W-1:0]      rank_t;
    typedef logic [MAX_FRAMES-1:0]  frame_mask_t;
    typedef page_t [MAX_FRAMES-1:0] page_vec_t;
    typedef rank_t [MAX_FRAMES-1:0] rank_vec_t;

    // Outcome of one lookup across the frame set.
    typedef struct packed {
        logic       hit;
        logic       evict;
        frame_idx_t slot;
    } lookup_t;

endpackage

@@ src/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement frame set
// Tracks resident pages in a set of frames and replaces the least recently
// used frame on a fault.
// ----------------------------------------------------------------------------
// A page reference is taken on every clock edge with start high; busy stays
// low, so the block takes one word per cycle with no gaps. Each reference
// gives exactly one result, shown for a single cycle with done high. The
// receiver cannot stall, so results must be taken as they appear. The
// reference passes through the input register, one pass of parallel
// compare and rank update, and the result register. The number
// of active frames is written through the cfg channel, which is always ready,
// and should only change while no reference is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_replacement
    import lpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_WIDTH-1:0]  page,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   done,
    output logic                   hit,
    output logic [FRAME_IDX_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_WIDTH-1:0]  evicted_page,
    output logic [FAULT_W-1:0]     fault_total
);

    logic               pend_reg;
    page_t              page_reg;
    logic [CFG_W-1:0]   frames_cfg_reg;
    page_vec_t          frame_page_reg;
    frame_mask_t        frame_valid_reg;
    frame_mask_t        frame_valid_next;
    rank_vec_t          rank_reg;
    rank_vec_t          rank_next;
    logic [FAULT_W-1:0] fault_cnt_reg;
    logic [FAULT_W-1:0] fault_cnt_next;
    logic               done_reg;
    logic               hit_reg;
    frame_idx_t         frame_index_reg;
    logic               evicted_valid_reg;
    page_t              evicted_page_reg;

    logic [CNT_W-1:0]   active_cnt;
    frame_mask_t        active;
    lookup_t            lk;
    rank_t              old_rank;
    page_t              evicted_page_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_cfg_reg <= cfg_data;
        end
    end

    // Out-of-range counts fold to the nearest legal value.
    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (32'(frames_cfg_reg) > 32'(MAX_FRAMES))
        begin
            active_cnt = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            active_cnt = CNT_W'(frames_cfg_reg);
        end
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            active[k] = (32'(k) < 32'(active_cnt));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            page_reg <= page;
        end
    end

    lpr_lookup u_lookup (
        .page        (page_reg),
        .frame_page  (frame_page_reg),
        .frame_valid (frame_valid_reg),
        .frame_rank  (rank_reg),
        .active      (active),
        .result      (lk)
    );

    assign old_rank = rank_reg[lk.slot];

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        frame_valid_next[lk.slot] = 1'b1;
        // The touched frame becomes newest; every younger frame ages by one.
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            if (FRAME_IDX_W'(k) == lk.slot)
            begin
                rank_next[k] = '0;
            end
            else if (rank_reg[k] < old_rank)
            begin
                rank_next[k] = rank_reg[k] + RANK_W'(1);
            end
            else
            begin
                rank_next[k] = rank_reg[k];
            end
        end
        if (!lk.hit && (fault_cnt_reg != '1))
        begin
            fault_cnt_next = fault_cnt_reg + FAULT_W'(1);
        end
        else
        begin
            fault_cnt_next = fault_cnt_reg;
        end
        evicted_page_next = lk.evict ? frame_page_reg[lk.slot] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            fault_cnt_reg   <= '0;
            done_reg        <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                rank_reg[k] <= RANK_W'(k);
            end
        end
        else
        begin
            done_reg <= pend_reg;
            if (pend_reg)
            begin
                frame_valid_reg <= frame_valid_next;
                rank_reg        <= rank_next;
                fault_cnt_reg   <= fault_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            if (!lk.hit)
            begin
                frame_page_reg[lk.slot] <= page_reg;
            end
            hit_reg           <= lk.hit;
            frame_index_reg   <= lk.slot;
            evicted_valid_reg <= lk.evict;
            evicted_page_reg  <= evicted_page_next;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_cnt_reg;

endmodule

@@ src/lpr_lookup.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement lookup
// Parallel compare of one page against all active frames, with selection of
// the hit frame, the lowest empty frame or the least recently used frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpr_lookup
    import lpr_pkg::*;
(
    input  page_t       page,
    input  page_vec_t   frame_page,
    input  frame_mask_t frame_valid,
    input  rank_vec_t   frame_rank,
    input  frame_mask_t active,
    output lookup_t     result
);

    frame_mask_t hit_vec;
    frame_mask_t empty_vec;
    frame_mask_t victim_vec;
    frame_idx_t  hit_idx;
    frame_idx_t  empty_idx;
    frame_idx_t  victim_idx;
    logic        any_empty;

    always_comb
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            hit_vec[k]   = frame_valid[k] & active[k] & (frame_page[k] == page);
            empty_vec[k] = active[k] & ~frame_valid[k];
            // Ranks are a permutation, so exactly one active frame is oldest.
            victim_vec[k] = active[k];
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if (active[j] && (frame_rank[j] > frame_rank[k]))
                begin
                    victim_vec[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit_idx    = '0;
        empty_idx  = '0;
        victim_idx = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                hit_idx = FRAME_IDX_W'(k);
            end
            if (empty_vec[k])
            begin
                empty_idx = FRAME_IDX_W'(k);
            end
            if (victim_vec[k])
            begin
                victim_idx = FRAME_IDX_W'(k);
            end
        end
    end

    assign any_empty = |empty_vec;

    always_comb
    begin
        result.hit   = |hit_vec;
        result.evict = ~result.hit & ~any_empty;
        if (result.hit)
        begin
            result.slot = hit_idx;
        end
        else if (any_empty)
        begin
            result.slot = empty_idx;
        end
        else
        begin
            result.slot = victim_idx;
        end
    end

endmodule

@@ src/lpr_checker.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level checks on result timing, eviction reporting and fault counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lru_page_replacement_assert.svh"

module lpr_checker
    import lpr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic                   hit,
    input logic                   evicted_valid,
    input logic [PAGE_WIDTH-1:0]  evicted_page,
    input logic [FAULT_W-1:0]     fault_total
);

    // Every accepted word must be followed by its result on done.
    `LPR_ASSERT_LAT2(a_result_latency, start && !busy, done, "result missing after accept")

    `LPR_ASSERT_IMP(a_hit_no_evict, done && hit, !evicted_valid, "eviction reported on a hit")

    `LPR_ASSERT_IMP(a_evict_page_zero, done && !evicted_valid, evicted_page == '0,
        "evicted page nonzero without eviction")

    // A fault advances the running count by one until it saturates.
    `LPR_ASSERT_IMP(a_fault_count, done && !hit && ($past(fault_total) != '1),
        fault_total == $past(fault_total) + FAULT_W'(1), "fault count did not advance")

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

@@ tb/sv/lru_page_checker.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Watches the reference, configuration and result channels of the frame set,
// predicts each result from its own copy of the frames, and compares every
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_checker
    import lpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [PAGE_WIDTH-1:0]  page,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   done,
    input  logic                   hit,
    input  logic [FRAME_IDX_W-1:0] frame_index,
    input  logic                   evicted_valid,
    input  logic [PAGE_WIDTH-1:0]  evicted_page,
    input  logic [FAULT_W-1:0]     fault_total,
    output int                     mismatch_count,
    output int                     outstanding,
    output int                     result_count,
    output int                     hit_count
);

    typedef struct packed {
        logic               hit;
        frame_idx_t         frame;
        logic               ev_valid;
        page_t              ev_page;
        logic [FAULT_W-1:0] faults;
    } page_outcome_t;

    page_t              frame_page  [MAX_FRAMES];
    logic               frame_valid [MAX_FRAMES];
    rank_t              recency     [MAX_FRAMES];
    logic [FAULT_W-1:0] fault_count;
    logic [CFG_W-1:0]   frames_cfg;
    page_outcome_t      pending_outcomes [$];

    function automatic int active_frames(input logic [CFG_W-1:0] c);
        if (c == '0)
            return 1;
        if (int'(c) > MAX_FRAMES)
            return MAX_FRAMES;
        return int'(c);
    endfunction

    // Looks the page up in the active frames, updates the frame contents and
    // the recency order, and returns the result the block should give.
    task automatic reference_page(input page_t p, output page_outcome_t r);
        int    n;
        int    slot;
        bit    found;
        rank_t oldest;
        rank_t old_rank;
        n     = active_frames(frames_cfg);
        slot  = 0;
        found = 1'b0;
        r     = '0;
        for (int k = 0; k < n; k++)
        begin
            if (!found && frame_valid[k] && frame_page[k] == p)
            begin
                slot  = k;
                found = 1'b1;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
        end
        else
        begin
            if (fault_count != '1)
                fault_count = fault_count + FAULT_W'(1);
            for (int k = 0; k < n; k++)
            begin
                if (!found && !frame_valid[k])
                begin
                    slot  = k;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                oldest = '0;
                for (int k = 0; k < n; k++)
                begin
                    if (recency[k] >= oldest)
                    begin
                        oldest = recency[k];
                        slot   = k;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[slot];
            end
            frame_page[slot]  = p;
            frame_valid[slot] = 1'b1;
        end
        // Inactive frames age too, so the whole rank set stays a permutation.
        old_rank = recency[slot];
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            if (recency[k] < old_rank)
                recency[k] = recency[k] + rank_t'(1);
        end
        recency[slot] = '0;
        r.frame       = frame_idx_t'(slot);
        r.faults      = fault_count;
    endtask

    task automatic compare_field(input string name, input logic [FAULT_W-1:0] want,
                                 input logic [FAULT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        page_outcome_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                frame_page[k]  = '0;
                frame_valid[k] = 1'b0;
                recency[k]     = rank_t'(k);
            end
            fault_count = '0;
            frames_cfg  = CFG_RESET;
            pending_outcomes.delete();
            mismatch_count = 0;
            outstanding    = 0;
            result_count   = 0;
            hit_count      = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, actual hit %0b frame %0d",
                             $time, hit, frame_index);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("hit", FAULT_W'(want.hit), FAULT_W'(hit));
                    compare_field("frame_index", FAULT_W'(want.frame), FAULT_W'(frame_index));
                    compare_field("evicted_valid", FAULT_W'(want.ev_valid),
                                  FAULT_W'(evicted_valid));
                    compare_field("evicted_page", FAULT_W'(want.ev_page),
                                  FAULT_W'(evicted_page));
                    compare_field("fault_total", want.faults, fault_total);
                    result_count++;
                    if (want.hit)
                        hit_count++;
                end
            end
            if (cfg_valid && cfg_ready)
                frames_cfg = cfg_data;
            if (start && !busy)
            begin
                reference_page(page, want);
                pending_outcomes.push_back(want);
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

@@ tb/sv/tb_lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references and frame-count writes into the frame set: a short
// directed sequence through fills, hits, evictions and odd frame counts, then
// random reference streams with working sets sized to the active frames,
// under several sender idle rates. The checker does all result checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENTS       = 8;
    localparam int SEG_ITEMS      = 56;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic [PAGE_WIDTH-1:0]  page      = '0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   busy;
    logic                   cfg_ready;
    logic                   done;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_WIDTH-1:0]  evicted_page;
    logic [FAULT_W-1:0]     fault_total;

    int mismatch_count;
    int outstanding;
    int result_count;
    int hit_count;
    int idle_pct   = 0;
    int items_sent = 0;
    int cfg_writes = 0;

    lru_page_replacement DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    lru_page_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .page           (page),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .hit            (hit),
        .frame_index    (frame_index),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_total    (fault_total),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .result_count   (result_count),
        .hit_count      (hit_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Ends the run when nothing has been accepted on any channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: watchdog expired with %0d results outstanding", $time, outstanding);
        $display("FAILURE");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is
    // taken, with start still high so back-to-back words need no gap.
    task automatic send_page(input page_t p);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            page  <= page_t'($urandom);
            @(negedge clk);
        end
        start <= 1'b1;
        page  <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly pages from a small window just wider than the active frames, so
    // hits and evictions both happen; the rest spread over the whole range.
    function automatic page_t next_page(input int active, input page_t base);
        if ($urandom_range(0, 99) < 80)
            return base + page_t'($urandom_range(0, active + 3));
        return page_t'($urandom);
    endfunction

    initial
    begin
        int    seg_cfg [SEGMENTS];
        int    idle_plan [4];
        int    active;
        page_t base;
        seg_cfg   = '{16, 1, 0, 2, 31, 17, 8, 5};
        idle_plan = '{0, 78, 0, 28};
        seg_cfg[6] = $urandom_range(1, 16);
        seg_cfg[7] = $urandom_range(0, 31);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset count of four: page zero must miss since frames start empty,
        // then fill, hit, and evict the least recently used frame.
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'hFFFF);
        send_page(16'h0005);

        // A single frame, then zero which acts as one.
        write_frames(5'd1);
        send_page(16'hFFFF);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        write_frames(5'd0);
        send_page(16'h5555);
        send_page(16'h5555);

        // Above the frame count acts as all frames; the upper frames are empty.
        write_frames(5'd31);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h8000);
        send_page(16'h0002);
        send_page(16'h7FFF);

        // Shrink, then grow again: hidden frames keep their pages, while their ranks still age.
        write_frames(5'd2);
        send_page(16'h1234);
        send_page(16'h4321);
        send_page(16'h0003);
        write_frames(5'd16);
        send_page(16'h1234);
        send_page(16'h8000);
        send_page(16'h7FFF);

        for (int s = 0; s < SEGMENTS; s++)
        begin
            write_frames(seg_cfg[s][CFG_W-1:0]);
            idle_pct = idle_plan[s % 4];
            active   = (seg_cfg[s] < 1) ? 1 : ((seg_cfg[s] > MAX_FRAMES) ? MAX_FRAMES : seg_cfg[s]);
            base     = page_t'($urandom);
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                if (s == 3 && i == SEG_ITEMS / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 3)
                    base = page_t'($urandom);
                send_page(next_page(active, base));
            end
        end

        drain_results();
        $display("Sent %0d page references over %0d frame-count writes; %0d results, %0d hits.",
                 items_sent, cfg_writes, result_count, hit_count);
        $display("Frame counts from 0 to 31 were used, with the sender idle up to 78%% of cycles.");
        if (mismatch_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
